### sv/rrt_pkg.sv
// ---------------------------------------------------------------------------
// rrt_pkg - shared types and codes for the tree extension checker
// Command kinds, status codes and the word that passes front to back.
// ---------------------------------------------------------------------------
package rrt_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_START  = 2'd2,
        KIND_SAMPLE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_ACK      = 3'd0,
        ST_ON_OBST  = 3'd1,
        ST_TOO_FAR  = 3'd2,
        ST_BLOCKED  = 3'd3,
        ST_ACCEPTED = 3'd4,
        ST_GOAL     = 3'd5,
        ST_DONE     = 3'd6,
        ST_FULL     = 3'd7
    } status_t;

    localparam int unsigned CFG_STEP      = 0;
    localparam int unsigned CFG_CLEARANCE = 1;
    localparam int unsigned CFG_MAX_ACC   = 2;
    localparam int unsigned CFG_START_X   = 3;
    localparam int unsigned CFG_START_Y   = 4;
    localparam int unsigned CFG_GOAL_X    = 5;
    localparam int unsigned CFG_GOAL_Y    = 6;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 16;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  parent_index;
        logic [15:0] parent_x;
        logic [15:0] parent_y;
        logic [8:0]  tree_size;
    } res_t;

endpackage

### sv/rrt_ram.sv
// ---------------------------------------------------------------------------
// rrt_ram - generic single port RAM
// One write or one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module rrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/rrt_front.sv
// ---------------------------------------------------------------------------
// rrt_front - input stage and command queue
// Accepts words and holds up to two in a small queue for the engine.
// ---------------------------------------------------------------------------
module rrt_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rrt_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output rrt_pkg::cmd_t q_cmd
);
    import rrt_pkg::*;

    cmd_t       slot_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= in_cmd;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end
endmodule

### sv/rrt_back.sv
// ---------------------------------------------------------------------------
// rrt_back - planning engine
// Sequencer walking obstacle and tree memories with a squared distance function.
// ---------------------------------------------------------------------------
module rrt_back #(
    parameter int TREE_NODES     = 256,
    parameter int OBSTACLE_SLOTS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [rrt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  rrt_pkg::cmd_t                    q_cmd,
    output logic                             res_valid,
    input  logic                             res_ready,
    output rrt_pkg::res_t                    res
);
    import rrt_pkg::*;

    localparam int TA = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
    localparam int OA = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;
    localparam int TC = $clog2(TREE_NODES + 1);
    localparam int OC = $clog2(OBSTACLE_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EQ, S_NN, S_NN_CHK, S_SEG_RD, S_SEG1, S_SEG2, S_SEG3,
        S_SEG_NEXT, S_WRITE, S_OUT
    } state_t;

    state_t state_reg;

    logic [14:0] step_reg, clear_reg;
    logic [7:0]  max_acc_reg;
    logic [15:0] start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;

    logic [OC-1:0] obs_cnt_reg;
    logic [TC-1:0] node_cnt_reg;
    logic [7:0]    acc_cnt_reg;
    logic          finished_reg;

    cmd_t          cmd_reg;
    logic [TC-1:0] idx_reg;
    logic          rd_pend_reg;
    logic [TA-1:0] best_reg;
    logic [32:0]   bd_reg;
    logic signed [15:0] par_x_reg, par_y_reg;
    logic          goal_pass_reg;
    logic signed [15:0] bx_reg, by_reg;
    logic signed [16:0] cx_reg, cy_reg, ax_reg, ay_reg;
    logic [33:0]   len_reg;
    logic signed [34:0] dot_reg;
    logic [33:0]   cr_reg;
    logic [29:0]   c2_reg;
    logic [67:0]   lhs_reg;
    logic [63:0]   rhs_reg;
    logic [32:0]   de_reg;
    logic [1:0]    mode_reg;
    res_t          res_reg;
    logic          res_valid_reg;

    // memories
    logic          o_we, t_we;
    logic [OA-1:0] o_addr;
    logic [TA-1:0] t_addr;
    logic [31:0]   o_wd, t_wd, o_rd, t_rd;

    rrt_ram #(.WIDTH(32), .DEPTH(OBSTACLE_SLOTS)) u_obs (
        .aclk(aclk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd));
    rrt_ram #(.WIDTH(32), .DEPTH(TREE_NODES)) u_tree (
        .aclk(aclk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));

    logic signed [15:0] ox, oy, tx, ty;
    assign ox = o_rd[31:16];
    assign oy = o_rd[15:0];
    assign tx = t_rd[31:16];
    assign ty = t_rd[15:0];

    // squared distance between two points
    function automatic logic [32:0] d2(input logic signed [15:0] x0, y0, x1, y1);
        logic signed [16:0] dx, dy;
        dx = 17'(x0) - 17'(x1);
        dy = 17'(y0) - 17'(y1);
        return 33'(34'(dx * dx) + 34'(dy * dy));
    endfunction

    logic [29:0] st2;
    assign st2 = 30'(step_reg * step_reg);

    always_comb begin
        o_we = 1'b0; t_we = 1'b0;
        o_addr = idx_reg[OA-1:0];
        t_addr = idx_reg[TA-1:0];
        o_wd = {cmd_reg.px, cmd_reg.py};
        t_wd = {cmd_reg.px, cmd_reg.py};
        if (state_reg == S_WRITE) begin
            case (cmd_reg.kind)
                KIND_ADD: begin
                    o_we = (obs_cnt_reg < OC'(OBSTACLE_SLOTS));
                    o_addr = obs_cnt_reg[OA-1:0];
                end
                KIND_START: begin
                    t_we = 1'b1; t_addr = '0;
                    t_wd = {start_x_reg, start_y_reg};
                end
                default: begin
                    t_we = 1'b1; t_addr = node_cnt_reg[TA-1:0];
                end
            endcase
        end
    end

    // a new word is only taken once the previous result has left
    assign q_pop     = (state_reg == S_IDLE) && q_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    logic [32:0] dcur;
    assign dcur = d2(tx, ty, cmd_reg.px, cmd_reg.py);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= 15'd256;
            clear_reg     <= 15'd128;
            max_acc_reg   <= 8'd255;
            start_x_reg   <= '0; start_y_reg <= '0;
            goal_x_reg    <= '0; goal_y_reg  <= '0;
            obs_cnt_reg   <= '0;
            node_cnt_reg  <= '0;
            acc_cnt_reg   <= '0;
            finished_reg  <= 1'b1;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (32'(cfg_idx))
                    CFG_STEP:      step_reg    <= cfg_data[14:0];
                    CFG_CLEARANCE: clear_reg   <= cfg_data[14:0];
                    CFG_MAX_ACC:   max_acc_reg <= cfg_data[7:0];
                    CFG_START_X:   start_x_reg <= cfg_data;
                    CFG_START_Y:   start_y_reg <= cfg_data;
                    CFG_GOAL_X:    goal_x_reg  <= cfg_data;
                    CFG_GOAL_Y:    goal_y_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && !res_valid_reg) begin
                        cmd_reg <= q_cmd;
                        idx_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        res_reg <= '0;
                        c2_reg <= 30'(clear_reg * clear_reg);
                        case (q_cmd.kind)
                            KIND_CLEAR: begin
                                obs_cnt_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            KIND_ADD: begin
                                if (obs_cnt_reg >= OC'(OBSTACLE_SLOTS)) begin
                                    res_reg.status <= ST_FULL;
                                end
                                state_reg <= S_WRITE;
                            end
                            KIND_START: state_reg <= S_WRITE;
                            default: begin
                                if (finished_reg || node_cnt_reg == '0) begin
                                    res_reg.status <= ST_DONE;
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_EQ;
                                end
                            end
                        endcase
                    end
                end
                // obstacle equality scan, one read a cycle
                S_EQ: begin
                    if (rd_pend_reg && ox == cmd_reg.px && oy == cmd_reg.py) begin
                        res_reg.status <= ST_ON_OBST;
                        state_reg <= S_OUT;
                    end else if (32'(idx_reg) >= OBSTACLE_SLOTS
                                 || idx_reg >= TC'(obs_cnt_reg)) begin
                        idx_reg <= '0; rd_pend_reg <= 1'b0;
                        state_reg <= S_NN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1; rd_pend_reg <= 1'b1;
                    end
                end
                S_NN: begin
                    if (rd_pend_reg && (idx_reg == TC'(1) || dcur < bd_reg)) begin
                        bd_reg <= dcur;
                        best_reg <= TA'(idx_reg - 1'b1);
                        par_x_reg <= tx; par_y_reg <= ty;
                    end
                    if (idx_reg >= node_cnt_reg) begin
                        state_reg <= S_NN_CHK;
                    end else begin
                        idx_reg <= idx_reg + 1'b1; rd_pend_reg <= 1'b1;
                    end
                end
                S_NN_CHK: begin
                    res_reg.parent_index <= 8'(best_reg);
                    res_reg.parent_x <= par_x_reg;
                    res_reg.parent_y <= par_y_reg;
                    if (bd_reg > 33'(st2)) begin
                        res_reg.status <= ST_TOO_FAR;
                        state_reg <= S_OUT;
                    end else begin
                        mode_reg <= 2'd0;
                        bx_reg <= par_x_reg; by_reg <= par_y_reg;
                        idx_reg <= '0;
                        state_reg <= S_SEG_RD;
                    end
                end
                S_SEG_RD: begin
                    cx_reg <= 17'(bx_reg) - 17'(cmd_reg.px);
                    cy_reg <= 17'(by_reg) - 17'(cmd_reg.py);
                    if (idx_reg >= TC'(obs_cnt_reg) || 32'(idx_reg) >= OBSTACLE_SLOTS) begin
                        // segment clear
                        if (mode_reg == 2'd0) begin
                            if (node_cnt_reg >= TC'(TREE_NODES)) begin
                                res_reg.status <= ST_FULL;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_WRITE;
                            end
                        end else begin
                            goal_pass_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= S_SEG1;
                    end
                end
                S_SEG1: begin
                    ax_reg <= 17'(ox) - 17'(cmd_reg.px);
                    ay_reg <= 17'(oy) - 17'(cmd_reg.py);
                    de_reg <= d2(ox, oy, bx_reg, by_reg);
                    len_reg <= 34'(cx_reg * cx_reg) + 34'(cy_reg * cy_reg);
                    state_reg <= S_SEG2;
                end
                S_SEG2: begin
                    dot_reg <= 35'(ax_reg * cx_reg) + 35'(ay_reg * cy_reg);
                    cr_reg <= 34'($unsigned((35'(ax_reg * cy_reg) - 35'(ay_reg * cx_reg))
                              < 0 ? -(35'(ax_reg * cy_reg) - 35'(ay_reg * cx_reg))
                              : (35'(ax_reg * cy_reg) - 35'(ay_reg * cx_reg))));
                    state_reg <= S_SEG3;
                end
                S_SEG3: begin
                    lhs_reg <= 68'(cr_reg * cr_reg);
                    rhs_reg <= 64'(c2_reg * len_reg);
                    state_reg <= S_SEG_NEXT;
                end
                S_SEG_NEXT: begin
                    logic close;
                    if (len_reg == '0 || dot_reg <= 0) begin
                        close = (34'(ax_reg * ax_reg) + 34'(ay_reg * ay_reg)) < 34'(c2_reg);
                    end else if (dot_reg >= 35'(len_reg)) begin
                        close = de_reg < 33'(c2_reg);
                    end else begin
                        close = lhs_reg < 68'(rhs_reg);
                    end
                    if (close) begin
                        if (mode_reg == 2'd0) begin
                            res_reg.status <= ST_BLOCKED;
                        end else begin
                            goal_pass_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_SEG_RD;
                    end
                end
                S_WRITE: begin
                    case (cmd_reg.kind)
                        KIND_ADD: begin
                            if (obs_cnt_reg < OC'(OBSTACLE_SLOTS)) begin
                                obs_cnt_reg <= obs_cnt_reg + 1'b1;
                            end
                            res_reg.tree_size <= 9'(node_cnt_reg);
                            res_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        KIND_START: begin
                            node_cnt_reg <= TC'(1);
                            acc_cnt_reg <= '0;
                            finished_reg <= (max_acc_reg == '0);
                            res_reg.tree_size <= 9'd1;
                            res_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        default: begin
                            node_cnt_reg <= node_cnt_reg + 1'b1;
                            goal_pass_reg <= 1'b0;
                            if (d2(cmd_reg.px, cmd_reg.py, goal_x_reg, goal_y_reg)
                                <= 33'(st2)) begin
                                mode_reg <= 2'd1;
                                bx_reg <= goal_x_reg; by_reg <= goal_y_reg;
                                idx_reg <= '0;
                                state_reg <= S_SEG_RD;
                            end else begin
                                state_reg <= S_OUT;
                                mode_reg <= 2'd1;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (!res_valid_reg || res_ready) begin
                        res_valid_reg <= 1'b1;
                        res_reg.tree_size <= 9'(node_cnt_reg);
                        if (cmd_reg.kind == KIND_SAMPLE && mode_reg == 2'd1
                            && res_reg.status == ST_ACK) begin
                            if (goal_pass_reg) begin
                                res_reg.status <= ST_GOAL;
                                finished_reg <= 1'b1;
                            end else begin
                                res_reg.status <= ST_ACCEPTED;
                                acc_cnt_reg <= acc_cnt_reg + 1'b1;
                                if (acc_cnt_reg + 1'b1 >= max_acc_reg) begin
                                    finished_reg <= 1'b1;
                                end
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            // the mode returns to the edge test whenever the engine is idle
            if (state_reg == S_IDLE) begin
                mode_reg <= 2'd0;
            end
        end
    end
endmodule

### sv/rrt_tree_extend_checker.sv
// ---------------------------------------------------------------------------
// rrt_tree_extend_checker - planner tree growth with collision checking
// Top level: command queue in front of the sequencing engine.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis word: kind, point_x, point_y; one m_axis word per input word.
//   Configuration is written on cfg_we/cfg_addr/cfg_wdata while idle.
//   A sample scans the obstacle memory once for equality, walks the tree
//   memory (one node a cycle), then checks the edge and possibly the goal
//   segment against each obstacle in states S_SEG_RD, S_SEG1, S_SEG2,
//   S_SEG3 and S_SEG_NEXT. Other commands pass through S_WRITE or S_OUT.
//   Each memory has a single port, so the scans read one entry at a time.
//   Two words can queue at the input while the engine works; a stalled
//   receiver holds the result and the engine takes no new word until the
//   result has been accepted.
//   Reset empties the queue, restores register defaults, clears counts.
// ---------------------------------------------------------------------------
module rrt_tree_extend_checker #(
    parameter int TREE_NODES     = 256,
    parameter int OBSTACLE_SLOTS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // point_x, point_y
    input  logic [1:0]                     s_tuser,  // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [55:0]                    m_tdata,  // parent_index, parent_x, parent_y, tree_size, pad
    output logic [2:0]                     m_tuser,  // status
    input  logic                           cfg_we,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [rrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rrt_pkg::*;

    cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop;
    res_t res;

    assign in_cmd.kind = kind_t'(s_tuser);
    assign in_cmd.px   = s_tdata[15:0];
    assign in_cmd.py   = s_tdata[31:16];

    rrt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

    rrt_back #(.TREE_NODES(TREE_NODES), .OBSTACLE_SLOTS(OBSTACLE_SLOTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_addr),
        .cfg_data(cfg_wdata), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res));

    assign m_tuser = res.status;
    assign m_tdata = {7'd0, res.tree_size, res.parent_y, res.parent_x, res.parent_index};
endmodule

### sv/rrt_checker.sv
// ---------------------------------------------------------------------------
// rrt_checker - port level checks for the tree extension checker
// Watches the result stream port and binds to the top level.
// ---------------------------------------------------------------------------
module rrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped under stall");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[55:49] == 7'd0)
        else $error("padding not zero");
    a_ack_noparent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == 3'd0 |-> m_tdata[39:0] == 40'd0)
        else $error("ack carries parent");
endmodule

bind rrt_tree_extend_checker rrt_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser));

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - testbench for rrt_tree_extend_checker
// Drives command words into the checker and compares every result word with
// a scoreboard that grows its own tree and obstacle table in step with it.
// ---------------------------------------------------------------------------
module tb;
    import rrt_pkg::*;

    localparam int NODES = 256;
    localparam int SLOTS = 64;

    class rrt_scoreboard;
        res_t           pending_q[$];
        int             errors;
        int unsigned    step_len, clear_d, max_acc;
        int             st_x, st_y, gl_x, gl_y;
        int             ox[SLOTS], oy[SLOTS];
        int             n_obs;
        int             tx[NODES], ty[NODES];
        int             n_nodes, n_acc;
        bit             finished;

        function new();
            errors   = 0;
            step_len = 256;
            clear_d  = 128;
            max_acc  = 255;
            st_x = 0; st_y = 0; gl_x = 0; gl_y = 0;
            n_obs = 0; n_nodes = 0; n_acc = 0;
            finished = 1'b1;
        endfunction

        function void set_reg(int unsigned idx, logic [15:0] v);
            case (idx)
                CFG_STEP:      step_len = v[14:0];
                CFG_CLEARANCE: clear_d  = v[14:0];
                CFG_MAX_ACC:   max_acc  = v[7:0];
                CFG_START_X:   st_x = $signed(v);
                CFG_START_Y:   st_y = $signed(v);
                CFG_GOAL_X:    gl_x = $signed(v);
                CFG_GOAL_Y:    gl_y = $signed(v);
                default: ;
            endcase
        endfunction

        function longint unsigned sq_dist(int ax, int ay, int bx, int by);
            longint dx, dy;
            dx = longint'(ax) - bx;
            dy = longint'(ay) - by;
            return longint'(dx * dx + dy * dy);
        endfunction

        // point strictly closer than sqrt(c2) to segment a-b, clamped to ends
        function bit near_segment(int px, int py, int ax, int ay, int bx, int by,
                                  longint unsigned c2);
            longint adx, ady, cx, cy, dot, len, cr;
            logic [127:0] lhs, rhs, ucr;
            adx = longint'(px) - ax; ady = longint'(py) - ay;
            cx  = longint'(bx) - ax; cy  = longint'(by) - ay;
            dot = adx * cx + ady * cy;
            len = cx * cx + cy * cy;
            if (len == 0 || dot <= 0) return sq_dist(px, py, ax, ay) < c2;
            if (dot >= len) return sq_dist(px, py, bx, by) < c2;
            cr  = adx * cy - ady * cx;
            ucr = (cr < 0) ? 128'(-cr) : 128'(cr);
            lhs = ucr * ucr;
            rhs = 128'(c2) * 128'(len);
            return lhs < rhs;
        endfunction

        function bit segment_blocked(int ax, int ay, int bx, int by);
            longint unsigned c2;
            c2 = longint'(clear_d) * clear_d;
            for (int i = 0; i < n_obs; i++)
                if (near_segment(ox[i], oy[i], ax, ay, bx, by, c2)) return 1'b1;
            return 1'b0;
        endfunction

        function void note_word(kind_t k, int x, int y);
            res_t            r;
            int              best;
            longint unsigned bd, d, st2;
            r = '0;
            r.status = ST_ACK;
            case (k)
                KIND_CLEAR: n_obs = 0;
                KIND_ADD: begin
                    if (n_obs >= SLOTS) r.status = ST_FULL;
                    else begin
                        ox[n_obs] = x; oy[n_obs] = y; n_obs++;
                    end
                end
                KIND_START: begin
                    tx[0] = st_x; ty[0] = st_y;
                    n_nodes = 1; n_acc = 0;
                    finished = (max_acc == 0);
                end
                default: begin
                    if (finished || n_nodes == 0) r.status = ST_DONE;
                    else begin
                        for (int i = 0; i < n_obs; i++)
                            if (ox[i] == x && oy[i] == y) r.status = ST_ON_OBST;
                        if (r.status == ST_ACK) begin
                            best = 0; bd = 0;
                            for (int i = 0; i < n_nodes; i++) begin
                                d = sq_dist(tx[i], ty[i], x, y);
                                if (i == 0 || d < bd) begin
                                    bd = d; best = i;
                                end
                            end
                            r.parent_index = best[7:0];
                            r.parent_x = tx[best][15:0];
                            r.parent_y = ty[best][15:0];
                            st2 = longint'(step_len) * step_len;
                            if (bd > st2) r.status = ST_TOO_FAR;
                            else if (segment_blocked(x, y, tx[best], ty[best]))
                                r.status = ST_BLOCKED;
                            else if (n_nodes >= NODES) r.status = ST_FULL;
                            else begin
                                tx[n_nodes] = x; ty[n_nodes] = y; n_nodes++;
                                if (sq_dist(x, y, gl_x, gl_y) <= st2 &&
                                    !segment_blocked(x, y, gl_x, gl_y)) begin
                                    r.status = ST_GOAL;
                                    finished = 1'b1;
                                end else begin
                                    r.status = ST_ACCEPTED;
                                    n_acc = (n_acc + 1) & 8'hFF;
                                    if (n_acc >= max_acc) finished = 1'b1;
                                end
                            end
                        end
                    end
                end
            endcase
            r.tree_size = n_nodes[8:0];
            pending_q = {pending_q, r};
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_word(res_t got);
            res_t e;
            if (pending_q.size() == 0) begin
                report("result word with nothing pending");
                return;
            end
            e = pending_q.pop_front();
            if (got.status != e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.parent_index != e.parent_index)
                report($sformatf("parent_index %0d, want %0d",
                                 got.parent_index, e.parent_index));
            if (got.parent_x != e.parent_x)
                report($sformatf("parent_x %h, want %h", got.parent_x, e.parent_x));
            if (got.parent_y != e.parent_y)
                report($sformatf("parent_y %h, want %h", got.parent_y, e.parent_y));
            if (got.tree_size != e.tree_size)
                report($sformatf("tree_size %0d, want %0d",
                                 got.tree_size, e.tree_size));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // point_x, point_y
    logic [1:0]            s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;   // parent_index, parent_x, parent_y, tree_size, pad
    logic [2:0]            m_tuser;   // status
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int            s_idle_pct;
    int            r_idle_pct;
    rrt_scoreboard sb;

    rrt_tree_extend_checker DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: sample before the edge's updates land
    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status       = status_t'(m_tuser);
            got.parent_index = m_tdata[7:0];
            got.parent_x     = m_tdata[23:8];
            got.parent_y     = m_tdata[39:24];
            got.tree_size    = m_tdata[48:40];
            sb.check_word(got);
        end
        m_tready <= ($urandom_range(99) >= r_idle_pct);
    end

    task automatic send_word(kind_t k, int x, int y);
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {y[15:0], x[15:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(k, $signed(x[15:0]), $signed(y[15:0]));
        if ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(int unsigned idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx[CFG_IDX_W-1:0];
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int jitter(int c, int span);
        return clamp16(c + $urandom_range(2 * span) - span);
    endfunction

    task automatic random_phase(int n, bit pause_mid);
        int pick, node, span, x, y;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) drain();
            pick = $urandom_range(99);
            span = (sb.step_len > 8000) ? 8000 : int'(sb.step_len) + 4;
            node = (sb.n_nodes > 0) ? $urandom_range(sb.n_nodes - 1) : 0;
            x = (sb.n_nodes > 0) ? sb.tx[node] : sb.st_x;
            y = (sb.n_nodes > 0) ? sb.ty[node] : sb.st_y;
            if (pick < 4)
                send_word(KIND_CLEAR, $urandom, $urandom);
            else if (pick < 14 && sb.n_obs < 24)
                send_word(KIND_ADD, jitter(x, 2 * span), jitter(y, 2 * span));
            else if (pick < 20 || (sb.finished && pick < 50))
                send_word(KIND_START, $urandom, $urandom);
            else if (pick < 28)
                send_word(KIND_SAMPLE, $urandom, $urandom);
            else if (pick < 34 && sb.n_obs > 0) begin
                node = $urandom_range(sb.n_obs - 1);
                send_word(KIND_SAMPLE, sb.ox[node], sb.oy[node]);
            end else if (pick < 40)
                send_word(KIND_SAMPLE, x, y);
            else
                send_word(KIND_SAMPLE, jitter(x, span + span / 4),
                          jitter(y, span + span / 4));
        end
    endtask

    task automatic set_plan(int stp, int clr, int mx, int sx, int sy, int gx, int gy);
        write_reg(CFG_STEP, 16'(stp));
        write_reg(CFG_CLEARANCE, 16'(clr));
        write_reg(CFG_MAX_ACC, 16'(mx));
        write_reg(CFG_START_X, 16'(sx));
        write_reg(CFG_START_Y, 16'(sy));
        write_reg(CFG_GOAL_X, 16'(gx));
        write_reg(CFG_GOAL_Y, 16'(gy));
    endtask

    initial begin
        sb         = new();
        s_idle_pct = 32;
        r_idle_pct = 79;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= KIND_CLEAR;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: no plan yet, then the basic outcomes
        send_word(KIND_SAMPLE, 10, 10);
        drain();
        set_plan(256, 128, 255, 0, 0, 0, 400);
        send_word(KIND_START, 0, 0);
        send_word(KIND_ADD, 150, 10);
        send_word(KIND_SAMPLE, 150, 10);      // on an obstacle
        send_word(KIND_SAMPLE, 1000, 0);      // too far
        send_word(KIND_SAMPLE, 200, 0);       // blocked
        send_word(KIND_SAMPLE, 0, -200);      // accepted
        send_word(KIND_SAMPLE, 0, -200);      // repeat, zero distance to its parent
        send_word(KIND_SAMPLE, 0, 200);       // goal
        send_word(KIND_SAMPLE, 0, 100);       // plan over
        send_word(KIND_SAMPLE, -32768, 32767);
        send_word(KIND_SAMPLE, 32767, -32768);
        send_word(KIND_START, 0, 0);
        send_word(KIND_SAMPLE, -32768, -32768);
        send_word(KIND_CLEAR, -1, -1);
        // fill the obstacle table and go one past
        for (int i = 0; i <= SLOTS; i++)
            send_word(KIND_ADD, 30000 - i, -30000 + i);
        send_word(KIND_SAMPLE, 50, 50);
        send_word(KIND_CLEAR, 0, 0);
        drain();

        for (int p = 0; p < 6; p++) begin
            s_idle_pct = (p < 2) ? 32 : (p < 4) ? 79 : 0;
            r_idle_pct = (p < 2) ? 79 : (p < 4) ? 32 : 0;
            case (p)
                0: set_plan(512, 128, 20, 0, 0, 2000, 2000);
                1: set_plan(32767, 0, 255, -32768, -32768, 32767, 32767);
                2: set_plan(0, 32767, 1, 32767, 32767, 32767, 32767);
                3: set_plan(300, 64, 1, 100, -100, -500, 500);
                4: set_plan(1024, 200, 60, 0, 0, 4000, -4000);
                default: set_plan(256, 128, 255, -200, 300, 5000, 5000);
            endcase
            send_word(KIND_CLEAR, 0, 0);
            send_word(KIND_START, 0, 0);
            random_phase(245, p == 1);
            drain();
        end

        repeat (2000) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
